// ----- src/dmacr_pkg.sv -----
// shared constants, codes and the address decode type of the dma register block
`timescale 1ns / 1ps
`default_nettype none
package dmacr_pkg;

    // channels present in the address map
    localparam int NUM_CHANNELS  = 7;
    // channels whose control write can raise an interrupt flag
    localparam int FLAG_CHANNELS = 6;
    localparam int CHAN_W        = 3;
    localparam int ENABLE_POS    = 16;
    localparam int FLAG_POS      = 24;
    localparam int BUSY_POS      = 24;

    localparam logic [31:0] BUSY_BIT     = 32'h0100_0000;
    localparam logic [31:0] BUSY_CLEAR   = 32'hfeff_ffff;
    localparam logic [31:0] FLAG_MASK    = 32'h7f00_0000;
    localparam logic [31:0] CH_BASE      = 32'h1f80_1080;
    localparam logic [31:0] PRIMARY_ADDR = 32'h1F80_10F0;
    localparam logic [31:0] INTCTL_ADDR  = 32'h1F80_10F4;

    typedef logic [1:0] t_op;
    localparam t_op OP_READ  = 2'd0;
    localparam t_op OP_WRITE = 2'd1;
    localparam t_op OP_TICK  = 2'd2;

    typedef logic [1:0] t_slot;
    localparam t_slot SLOT_MADR = 2'd0;
    localparam t_slot SLOT_BCR  = 2'd1;
    localparam t_slot SLOT_CHCR = 2'd2;

    typedef struct packed {
        logic              hit_primary;
        logic              hit_int;
        logic              hit_chan;
        logic [CHAN_W-1:0] chan;
        t_slot             slot;
    } t_dec;

endpackage
`default_nettype wire

// ----- src/dmacr_decode.sv -----
// bus address decode for the dma channel and control registers
`timescale 1ns / 1ps
`default_nettype none
module dmacr_decode (
    input  wire logic [31:0]      i_address,
    output dmacr_pkg::t_dec       o_dec
);

    logic                 w_slot_ok;
    dmacr_pkg::t_slot     w_slot;
    logic                 w_in_window;
    logic                 w_chan_ok;

    always_comb begin
        w_slot_ok = 1'b1;
        case (i_address[3:0])
            4'h0: begin
                w_slot = dmacr_pkg::SLOT_MADR;
            end
            4'h4: begin
                w_slot = dmacr_pkg::SLOT_BCR;
            end
            4'h8: begin
                w_slot = dmacr_pkg::SLOT_CHCR;
            end
            default: begin
                w_slot    = dmacr_pkg::SLOT_MADR;
                w_slot_ok = 1'b0;
            end
        endcase
    end

    // channel window is 128-byte aligned, so the upper bits pick it
    assign w_in_window = (i_address[31:7] == dmacr_pkg::CH_BASE[31:7]);
    assign w_chan_ok   = ({29'd0, i_address[6:4]} < 32'(dmacr_pkg::NUM_CHANNELS));

    assign o_dec.hit_primary = (i_address == dmacr_pkg::PRIMARY_ADDR);
    assign o_dec.hit_int     = (i_address == dmacr_pkg::INTCTL_ADDR);
    assign o_dec.hit_chan    = w_in_window && w_chan_ok && w_slot_ok;
    assign o_dec.chan        = i_address[6:4];
    assign o_dec.slot        = w_slot;

endmodule
`default_nettype wire

// ----- src/dma_channel_register_block.sv -----
// top level of the dma controller register file: request stage, register update, result stage
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+-----------------------------------
//  request | in        | i_in_valid/o_in_stall | i_op, i_address, i_write_value
//  result  | out       | o_out_valid/i_out_stall | o_read_value, o_irq
//
// one request per cycle while the result is not stalled; a result is offered once its request
// has passed the request register, then decode and register update into the result register
// reset is synchronous and active low and clears the valid flags and all control registers
// a stalled result holds; the request register takes one more request, then the input stalls
// a request sees every register update made by the requests taken before it
`timescale 1ns / 1ps
`default_nettype none
module dma_channel_register_block (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [1:0]  i_op,
    input  wire logic [31:0] i_address,
    input  wire logic [31:0] i_write_value,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [31:0]      o_read_value,
    output logic             o_irq
);

    localparam int NCH = dmacr_pkg::NUM_CHANNELS;

    // request stage
    logic                 r_s1_valid;
    dmacr_pkg::t_op       r_s1_op;
    logic [31:0]          r_s1_address;
    logic [31:0]          r_s1_data;

    // result stage
    logic                 r_out_valid;
    logic [31:0]          r_read_value;
    logic                 r_irq;

    // register file
    logic [31:0]          r_madr [NCH];
    logic [31:0]          r_bcr  [NCH];
    logic [31:0]          r_chcr [NCH];
    logic [31:0]          r_primary;
    logic [31:0]          r_int_ctrl;

    logic                 w_out_ready;
    logic                 w_in_ready;
    logic                 w_in_fire;
    logic                 w_s1_fire;
    logic                 w_wr;
    logic                 w_chcr_wr;
    logic                 w_int_wr;
    logic [NCH-1:0]       w_flag_set;
    dmacr_pkg::t_dec      w_dec;
    logic [31:0]          n_int_ctrl;
    logic [31:0]          n_read_value;
    logic                 n_irq;
    logic [NCH-1:0]       w_busy_bits;

    function automatic logic [dmacr_pkg::CHAN_W-1:0] CHAN_IDX(input int c);
        CHAN_IDX = dmacr_pkg::CHAN_W'(c);
    endfunction

    dmacr_decode u_decode (
        .i_address (r_s1_address),
        .o_dec     (w_dec)
    );

    assign w_out_ready = !r_out_valid || !i_out_stall;
    assign w_in_ready  = !r_s1_valid || w_out_ready;
    assign w_in_fire   = i_in_valid && w_in_ready;
    assign w_s1_fire   = r_s1_valid && w_out_ready;
    assign o_in_stall  = !w_in_ready;

    assign w_wr     = w_s1_fire && (r_s1_op == dmacr_pkg::OP_WRITE);
    assign w_int_wr = w_wr && w_dec.hit_int;
    // a control write only lands while the stored busy bit is clear
    assign w_chcr_wr = w_wr && w_dec.hit_chan && (w_dec.slot == dmacr_pkg::SLOT_CHCR)
                       && !r_chcr[w_dec.chan][dmacr_pkg::BUSY_POS];

    always_comb begin
        w_flag_set = '0;
        for (int c = 0; c < NCH; c++) begin
            if (c < dmacr_pkg::FLAG_CHANNELS) begin
                w_flag_set[c] = (w_dec.chan == CHAN_IDX(c))
                                && r_int_ctrl[dmacr_pkg::ENABLE_POS + c];
            end
        end
    end

    always_comb begin
        n_int_ctrl = r_int_ctrl;
        if (w_int_wr) begin
            n_int_ctrl = r_s1_data;
        end else if (w_chcr_wr) begin
            n_int_ctrl = r_int_ctrl | (32'(w_flag_set) << dmacr_pkg::FLAG_POS);
        end
    end

    always_comb begin
        n_read_value = '0;
        n_irq        = 1'b0;
        case (r_s1_op)
            dmacr_pkg::OP_READ: begin
                if (w_dec.hit_primary) begin
                    n_read_value = r_primary;
                end else if (w_dec.hit_int) begin
                    n_read_value = r_int_ctrl;
                end else if (w_dec.hit_chan) begin
                    case (w_dec.slot)
                        dmacr_pkg::SLOT_MADR: n_read_value = r_madr[w_dec.chan];
                        dmacr_pkg::SLOT_BCR:  n_read_value = r_bcr[w_dec.chan];
                        dmacr_pkg::SLOT_CHCR: n_read_value = r_chcr[w_dec.chan];
                        default:              n_read_value = '0;
                    endcase
                end
            end
            dmacr_pkg::OP_TICK: begin
                n_irq = |(r_int_ctrl & dmacr_pkg::FLAG_MASK);
            end
            default: begin
                n_read_value = '0;
                n_irq        = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_in_fire) begin
            r_s1_valid <= 1'b1;
        end else if (w_s1_fire) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_s1_op      <= i_op;
            r_s1_address <= i_address;
            r_s1_data    <= i_write_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_s1_fire) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_fire) begin
            r_read_value <= n_read_value;
            r_irq        <= n_irq;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < NCH; c++) begin
                r_madr[c] <= '0;
                r_bcr[c]  <= '0;
                r_chcr[c] <= '0;
            end
            r_primary  <= '0;
            r_int_ctrl <= '0;
        end else begin
            r_int_ctrl <= n_int_ctrl;
            if (w_wr && w_dec.hit_primary) begin
                r_primary <= r_s1_data;
            end
            for (int c = 0; c < NCH; c++) begin
                if (w_wr && w_dec.hit_chan && (w_dec.chan == CHAN_IDX(c))) begin
                    if (w_dec.slot == dmacr_pkg::SLOT_MADR) begin
                        r_madr[c] <= r_s1_data;
                    end
                    if (w_dec.slot == dmacr_pkg::SLOT_BCR) begin
                        r_bcr[c] <= r_s1_data;
                    end
                    if (w_chcr_wr) begin
                        r_chcr[c] <= r_s1_data & dmacr_pkg::BUSY_CLEAR;
                    end
                end
            end
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_read_value = r_read_value;
    assign o_irq        = r_irq;

    always_comb begin
        for (int c = 0; c < NCH; c++) begin
            w_busy_bits[c] = r_chcr[c][dmacr_pkg::BUSY_POS];
        end
    end

    // stored busy bits can never be set by a write
    a_busy_never_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_busy_bits == '0)
        else $error("channel control busy bit set");

    // only a tick drives the interrupt line, and a tick returns no data
    a_irq_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_irq) |-> (r_read_value == '0))
        else $error("interrupt result carries read data");

    // a waiting request is held while the result stage is blocked
    a_s1_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_out_valid && i_out_stall) |=> r_s1_valid)
        else $error("request lost while result stalled");

    // channel 6 has no flag path; its flag moves only on an interrupt control write
    a_flag6_only_direct: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_int_wr |=> $stable(r_int_ctrl[30]))
        else $error("channel 6 interrupt flag changed without a direct write");

endmodule
`default_nettype wire
